FILE: rtl/core/tem_pkg.sv
// Package for the tunnel endpoint map table: beat types, operation and status codes,
// table geometry and small helpers shared by the core modules and the checker.
// Depends on nothing.
`default_nettype none

package tem_pkg;

    // Table geometry.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Operation codes carried in the func field.
    localparam logic [2:0] FN_LOOKUP4 = 3'd0;
    localparam logic [2:0] FN_LOOKUP6 = 3'd1;
    localparam logic [2:0] FN_SET     = 3'd2;
    localparam logic [2:0] FN_REMOVE  = 3'd3;
    localparam logic [2:0] FN_CLEAR   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] ipv4_addr;
        logic [63:0] ipv6_high;
        logic [63:0] ipv6_low;
        logic [15:0] tag;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_ipv4;
        logic [63:0] found_ipv6_high;
        logic [63:0] found_ipv6_low;
        logic [15:0] found_tag;
    } t_out_beat;

    // One stored table entry.
    typedef struct packed {
        logic [31:0] ipv4;
        logic [63:0] ipv6_hi;
        logic [63:0] ipv6_lo;
        logic [15:0] tag;
    } t_slot;

    // Result beat that reports a stored entry.
    function automatic t_out_beat make_hit(input t_slot entry);
        t_out_beat beat;
        beat.status          = ST_OK;
        beat.found_ipv4      = entry.ipv4;
        beat.found_ipv6_high = entry.ipv6_hi;
        beat.found_ipv6_low  = entry.ipv6_lo;
        beat.found_tag       = entry.tag;
        return beat;
    endfunction

    // Result beat with a status and all entry fields zero.
    function automatic t_out_beat make_empty(input logic [1:0] status);
        t_out_beat beat;
        beat        = '0;
        beat.status = status;
        return beat;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tem_slot_ram.sv
// Slot store of the tunnel endpoint map table: one write port and one read port
// with registered read data. Depends on tem_pkg.
`default_nettype none

module tem_slot_ram
    import tem_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_slot            i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_slot                 o_rdata
);

    t_slot r_mem [CAPACITY];
    t_slot r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/tem_match_unit.sv
// Shared compare unit: checks one stored slot against the request key or endpoint.
// Depends on tem_pkg.
`default_nettype none

module tem_match_unit
    import tem_pkg::*;
(
    input  wire logic     i_slot_valid,
    input  wire t_slot    i_entry,
    input  wire t_in_beat i_req,
    output logic          o_hit
);

    logic key_eq;
    logic ep_eq;

    // Key compare and full 128-bit endpoint compare.
    assign key_eq = (i_entry.ipv4 == i_req.ipv4_addr);
    assign ep_eq  = (i_entry.ipv6_hi == i_req.ipv6_high) && (i_entry.ipv6_lo == i_req.ipv6_low);

    // A reverse lookup matches on the endpoint, every other scan on the key.
    assign o_hit = i_slot_valid && ((i_req.func == FN_LOOKUP6) ? ep_eq : key_eq);

endmodule

`default_nettype wire

FILE: rtl/core/tunnel_endpoint_map_table_unit.sv
// Tunnel endpoint map table: lookups, set, remove and clear run over CAPACITY slots.
// Lookup, set and remove scan the slots one slot per cycle through the single memory
// read port; clear all and unused codes skip the scan and go straight to the result.
// Throughput: one item at a time; the input is not ready until the result is taken.
// Reset empties the table at once through per-slot valid flops; there is no clear pass.
`default_nettype none

module tunnel_endpoint_map_table_unit
    import tem_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [1:0]          r_state, n_state;
    t_in_beat            r_req, n_req;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                r_free_found, n_free_found;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic [CAPACITY-1:0] r_slot_valid, n_slot_valid;
    t_out_beat           r_out, n_out;

    logic             scan_live;
    logic [IDX_W-1:0] scan_slot;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_slot            ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_slot            rd_entry;
    logic             hit;
    t_slot            new_entry;

    assign scan_live = (r_idx < CAP_CNT);
    assign scan_slot = r_idx[IDX_W-1:0];
    assign ram_raddr = scan_live ? scan_slot : '0;

    // Slot memory.
    tem_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    // Compare of the slot read in the previous cycle.
    tem_match_unit u_match (
        .i_slot_valid (r_slot_valid[r_cmp_idx]),
        .i_entry      (rd_entry),
        .i_req        (r_req),
        .o_hit        (hit)
    );

    // Entry written by a set whose key is absent.
    always_comb begin
        new_entry.ipv4    = r_req.ipv4_addr;
        new_entry.ipv6_hi = r_req.ipv6_high;
        new_entry.ipv6_lo = r_req.ipv6_low;
        new_entry.tag     = r_req.tag;
    end

    // Sequencer: accept, scan one slot per cycle where the operation needs it, then hold the result.
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_slot_valid = r_slot_valid;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = r_cmp_idx;
        ram_wdata    = rd_entry;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req        = i_in_beat;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    priority if (i_in_beat.func == FN_CLEAR) begin
                        n_slot_valid = '0;
                        n_out        = make_empty(ST_OK);
                        n_state      = S_OUT;
                    end else if (i_in_beat.func == FN_LOOKUP4 || i_in_beat.func == FN_LOOKUP6 ||
                                 i_in_beat.func == FN_SET || i_in_beat.func == FN_REMOVE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_out   = make_empty(ST_MISS);
                        n_state = S_OUT;
                    end
                end
            end

            S_SCAN: begin
                // Issue the next read and note the lowest free slot.
                if (scan_live) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = scan_slot;
                    n_idx     = r_idx + 1'b1;
                    if (!r_free_found && !r_slot_valid[scan_slot]) begin
                        n_free_found = 1'b1;
                        n_free_idx   = scan_slot;
                    end
                end

                if (r_cmp_vld && hit) begin
                    // First matching slot decides the result.
                    n_state = S_OUT;
                    unique case (r_req.func)
                        FN_SET: begin
                            ram_we            = 1'b1;
                            ram_waddr         = r_cmp_idx;
                            ram_wdata         = rd_entry;
                            ram_wdata.ipv6_hi = r_req.ipv6_high;
                            ram_wdata.ipv6_lo = r_req.ipv6_low;
                            n_out             = make_hit(ram_wdata);
                        end
                        FN_REMOVE: begin
                            if (rd_entry.tag == r_req.tag) begin
                                n_slot_valid[r_cmp_idx] = 1'b0;
                                n_out                   = make_hit(rd_entry);
                            end else begin
                                n_out = make_empty(ST_MISS);
                            end
                        end
                        default: begin
                            n_out = make_hit(rd_entry);
                        end
                    endcase
                end else if (!r_cmp_vld && !scan_live) begin
                    // Whole table scanned without a match.
                    n_state = S_OUT;
                    if (r_req.func == FN_SET) begin
                        if (r_free_found) begin
                            ram_we                   = 1'b1;
                            ram_waddr                = r_free_idx;
                            ram_wdata                = new_entry;
                            n_slot_valid[r_free_idx] = 1'b1;
                            n_out                    = make_hit(new_entry);
                        end else begin
                            n_out = make_empty(ST_FULL);
                        end
                    end else begin
                        n_out = make_empty(ST_MISS);
                    end
                end
            end

            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cmp_vld    <= 1'b0;
            r_slot_valid <= '0;
        end else begin
            r_state      <= n_state;
            r_cmp_vld    <= n_cmp_vld;
            r_slot_valid <= n_slot_valid;
        end
    end

    // Request, scan position and result registers.
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_out        <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/tem_checker.sv
// Port checker for the tunnel endpoint map table, bound to the top level.
// Depends on tem_pkg and tunnel_endpoint_map_table_unit.
`default_nettype none

module tem_checker
    import tem_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_beat  i_in_beat,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_beat o_out_beat
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    // One item at a time: no input is taken while a result is pending.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // An accepted beat closes the input straight after the accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready straight after an accept");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.status == ST_OK || o_out_beat.status == ST_MISS ||
                         o_out_beat.status == ST_FULL))
        else $error("undefined status code");

    // Failed operations carry zero entry fields.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status != ST_OK |->
            o_out_beat.found_ipv4 == '0 && o_out_beat.found_ipv6_high == '0 &&
            o_out_beat.found_ipv6_low == '0 && o_out_beat.found_tag == '0)
        else $error("non-zero entry fields on a failed operation");

endmodule

bind tunnel_endpoint_map_table_unit tem_checker u_tem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire
